@@ rtl/owr_pkg.sv @@
// Package with the constants and types shared by the one-wire temperature reader.
`default_nettype none
package owr_pkg;

   localparam int SCRATCH_BYTES_DEFAULT = 2;

   localparam int US_CNT_WIDTH    = 20;
   localparam int RESET_LOW_WIDTH = 10;
   localparam int CONV_WAIT_WIDTH = 20;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam int TEMP_WIDTH      = 12;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RESET_LOW_US    = 2'd0,
      CSR_CONVERT_WAIT_US = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_PRES_CONV = 2'd1,
      STATUS_NO_PRES_READ = 2'd2
   } status_type;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   localparam logic [RESET_LOW_WIDTH-1:0] RESET_LOW_US_RESET    = 10'd750;
   localparam logic [CONV_WAIT_WIDTH-1:0] CONVERT_WAIT_US_RESET = 20'd750000;

   localparam logic [US_CNT_WIDTH-1:0] RELEASE_US      = 20'd15;
   localparam logic [US_CNT_WIDTH-1:0] PRES_HIGH_LIMIT = 20'd200;
   localparam logic [US_CNT_WIDTH-1:0] PRES_LOW_LIMIT  = 20'd240;
   localparam logic [US_CNT_WIDTH-1:0] WR_SLOT_US      = 20'd62;
   localparam logic [US_CNT_WIDTH-1:0] WR_ONE_LOW_US   = 20'd2;
   localparam logic [US_CNT_WIDTH-1:0] WR_ZERO_LOW_US  = 20'd60;
   localparam logic [US_CNT_WIDTH-1:0] RD_SLOT_US      = 20'd64;
   localparam logic [US_CNT_WIDTH-1:0] RD_LOW_US       = 20'd2;
   localparam logic [US_CNT_WIDTH-1:0] RD_SAMPLE_AT    = 20'd14;

   // Accepted raw range, in sixteenths of a degree: between -55.0 and 125.0 degrees, both bounds excluded.
   localparam logic signed [15:0] RAW_LOW_BOUND  = -16'sd880;
   localparam logic signed [15:0] RAW_HIGH_BOUND = 16'sd2000;

endpackage
`default_nettype wire

@@ rtl/owr_req_if.sv @@
// Input channel interface: one sampled bus level and start flag per microsecond tick.
`default_nettype none
interface owr_req_if;
   logic valid;
   logic ready;
   logic line_level;
   logic start_request;

   modport source (output valid, output line_level, output start_request, input ready);
   modport sink (input valid, input line_level, input start_request, output ready);
endinterface
`default_nettype wire

@@ rtl/owr_rsp_if.sv @@
// Result channel interface: bus drive, busy flag and measurement result per tick.
`default_nettype none
interface owr_rsp_if
   import owr_pkg::*;
;
   logic                         valid;
   logic                         ready;
   logic                         drive_low;
   logic                         busy_res;
   logic                         result_valid;
   logic [1:0]                   status;
   logic signed [TEMP_WIDTH-1:0] temperature;
   logic                         in_range;

   modport source (output valid, output drive_low, output busy_res, output result_valid,
                   output status, output temperature, output in_range, input ready);
   modport sink (input valid, input drive_low, input busy_res, input result_valid,
                 input status, input temperature, input in_range, output ready);
endinterface
`default_nettype wire

@@ rtl/owr_csr_if.sv @@
// Configuration write channel interface: register index and write data.
`default_nettype none
interface owr_csr_if
   import owr_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [CSR_DATA_WIDTH-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface
`default_nettype wire

@@ rtl/one_wire_temp_sensor_reader.sv @@
// One-wire bus master that runs a temperature conversion and scratchpad read per request.
//
// Each req_ch transaction is one microsecond tick: the sampled bus level and a start
// flag. Each tick yields exactly one rsp_ch transaction: the open-drain drive for the
// next microsecond, the busy flag, and on the tick a sequence ends a result with
// status, temperature in sixteenths of a degree and the in-range flag.
// The state update sits between the input handshake and a single output register,
// so a result is registered in the cycle after its tick is accepted, and one tick can
// be accepted in every cycle while the output register is empty or being taken.
// req_ch.ready stays high while the output register is empty or being taken, so a
// stalled receiver holds req_ch off only once its one result waits.
// csr_ch is always ready; register 0 is the reset pulse length, register 1 the
// conversion wait, both in ticks. The user writes while the block is idle; nothing checks it.
// Synchronous reset returns the sequencer to idle, restores the register defaults
// (750 and 750000) and empties the output register.
`default_nettype none
module one_wire_temp_sensor_reader
   import owr_pkg::*;
#(
   parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   owr_req_if.sink    req_ch,
   owr_rsp_if.source  rsp_ch,
   owr_csr_if.sink    csr_ch
);

   localparam int BYTE_WIDTH = $clog2(SCRATCH_BYTES + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_REL,
      PH_PRES_LOW,
      PH_PRES_HIGH,
      PH_WRITE,
      PH_CONV,
      PH_READ
   } phase_type;

   logic [RESET_LOW_WIDTH-1:0] reset_low_us_ff;
   logic [CONV_WAIT_WIDTH-1:0] convert_wait_us_ff;

   phase_type               phase_ff, phase_in;
   logic [US_CNT_WIDTH-1:0] us_counter_ff, us_counter_in;
   logic [2:0]              bit_counter_ff, bit_counter_in;
   logic [BYTE_WIDTH-1:0]   byte_counter_ff, byte_counter_in;
   logic [7:0]              shift_byte_ff, shift_byte_in;
   logic [7:0]              low_byte_ff, low_byte_in;
   logic [7:0]              high_byte_ff, high_byte_in;
   logic                    reading_pass_ff, reading_pass_in;

   logic                         rsp_valid_ff;
   logic                         drive_low_ff, drive_low_in;
   logic                         busy_res_ff;
   logic                         result_valid_ff, result_valid_in;
   logic [1:0]                   status_ff, status_in;
   logic signed [TEMP_WIDTH-1:0] temperature_ff, temperature_in;
   logic                         in_range_ff, in_range_in;

   logic                    req_accept;
   logic [US_CNT_WIDTH-1:0] us_inc;
   logic [2:0]              bit_inc;
   logic [BYTE_WIDTH-1:0]   byte_inc;
   logic signed [15:0]      raw_reading;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign us_inc   = us_counter_ff + 1'b1;
   assign bit_inc  = bit_counter_ff + 1'b1;
   assign byte_inc = BYTE_WIDTH'(byte_counter_ff + 1'b1);

   always_comb begin
      phase_in        = phase_ff;
      us_counter_in   = us_counter_ff;
      bit_counter_in  = bit_counter_ff;
      byte_counter_in = byte_counter_ff;
      shift_byte_in   = shift_byte_ff;
      low_byte_in     = low_byte_ff;
      high_byte_in    = high_byte_ff;
      reading_pass_in = reading_pass_ff;
      drive_low_in    = 1'b0;
      result_valid_in = 1'b0;
      status_in       = STATUS_OK;
      temperature_in  = '0;
      in_range_in     = 1'b0;
      raw_reading     = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (req_ch.start_request) begin
               phase_in        = PH_RST_LOW;
               us_counter_in   = '0;
               reading_pass_in = 1'b0;
            end
         end
         PH_RST_LOW: begin
            drive_low_in  = 1'b1;
            us_counter_in = us_inc;
            if (us_inc >= US_CNT_WIDTH'(reset_low_us_ff)) begin
               phase_in      = PH_RST_REL;
               us_counter_in = '0;
            end
         end
         PH_RST_REL: begin
            us_counter_in = us_inc;
            if (us_inc >= RELEASE_US) begin
               phase_in      = PH_PRES_LOW;
               us_counter_in = '0;
            end
         end
         PH_PRES_LOW, PH_PRES_HIGH: begin
            if ((phase_ff == PH_PRES_LOW) ? !req_ch.line_level : req_ch.line_level) begin
               us_counter_in = '0;
               if (phase_ff == PH_PRES_LOW) begin
                  phase_in = PH_PRES_HIGH;
               end else begin
                  phase_in        = PH_WRITE;
                  bit_counter_in  = '0;
                  byte_counter_in = '0;
                  shift_byte_in   = CMD_SKIP_ROM;
               end
            end else begin
               us_counter_in = us_inc;
               if (us_inc >= ((phase_ff == PH_PRES_LOW) ? PRES_HIGH_LIMIT
                                                        : PRES_LOW_LIMIT)) begin
                  result_valid_in = 1'b1;
                  status_in       = reading_pass_ff ? STATUS_NO_PRES_READ
                                                    : STATUS_NO_PRES_CONV;
                  phase_in        = PH_IDLE;
                  us_counter_in   = '0;
                  reading_pass_in = 1'b0;
               end
            end
         end
         PH_WRITE: begin
            drive_low_in  = us_counter_ff < (shift_byte_ff[0] ? WR_ONE_LOW_US
                                                              : WR_ZERO_LOW_US);
            us_counter_in = us_inc;
            if (us_inc >= WR_SLOT_US) begin
               us_counter_in  = '0;
               shift_byte_in  = {1'b0, shift_byte_ff[7:1]};
               bit_counter_in = bit_inc;
               if (bit_inc == 3'd0) begin
                  if (byte_counter_ff == '0) begin
                     byte_counter_in = BYTE_WIDTH'(1);
                     shift_byte_in   = reading_pass_ff ? CMD_READ_PAD : CMD_CONVERT;
                  end else begin
                     byte_counter_in = '0;
                     shift_byte_in   = '0;
                     phase_in        = reading_pass_ff ? PH_READ : PH_CONV;
                  end
               end
            end
         end
         PH_CONV: begin
            us_counter_in = us_inc;
            if (us_inc >= convert_wait_us_ff) begin
               phase_in        = PH_RST_LOW;
               us_counter_in   = '0;
               reading_pass_in = 1'b1;
            end
         end
         PH_READ: begin
            drive_low_in = us_counter_ff < RD_LOW_US;
            if (us_counter_ff == RD_SAMPLE_AT) begin
               shift_byte_in = {req_ch.line_level, shift_byte_ff[7:1]};
            end
            us_counter_in = us_inc;
            if (us_inc >= RD_SLOT_US) begin
               us_counter_in  = '0;
               bit_counter_in = bit_inc;
               if (bit_inc == 3'd0) begin
                  if (byte_counter_ff == '0) begin
                     low_byte_in = shift_byte_in;
                  end else if (byte_counter_ff == BYTE_WIDTH'(1)) begin
                     high_byte_in = shift_byte_in;
                  end
                  byte_counter_in = byte_inc;
                  if (byte_inc >= BYTE_WIDTH'(SCRATCH_BYTES)) begin
                     raw_reading     = {high_byte_in, low_byte_in};
                     in_range_in     = (raw_reading > RAW_LOW_BOUND) &&
                                       (raw_reading < RAW_HIGH_BOUND);
                     temperature_in  = in_range_in ? raw_reading[TEMP_WIDTH-1:0] : '0;
                     result_valid_in = 1'b1;
                     phase_in        = PH_IDLE;
                     byte_counter_in = '0;
                     reading_pass_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            phase_in      = PH_IDLE;
            us_counter_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_us_ff    <= RESET_LOW_US_RESET;
         convert_wait_us_ff <= CONVERT_WAIT_US_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_RESET_LOW_US:    reset_low_us_ff    <= csr_ch.write_data[RESET_LOW_WIDTH-1:0];
            CSR_CONVERT_WAIT_US: convert_wait_us_ff <= csr_ch.write_data[CONV_WAIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         us_counter_ff   <= '0;
         bit_counter_ff  <= '0;
         byte_counter_ff <= '0;
         shift_byte_ff   <= '0;
         low_byte_ff     <= '0;
         high_byte_ff    <= '0;
         reading_pass_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         us_counter_ff   <= us_counter_in;
         bit_counter_ff  <= bit_counter_in;
         byte_counter_ff <= byte_counter_in;
         shift_byte_ff   <= shift_byte_in;
         low_byte_ff     <= low_byte_in;
         high_byte_ff    <= high_byte_in;
         reading_pass_ff <= reading_pass_in;
         rsp_valid_ff    <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload loads with each accepted tick and needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         drive_low_ff    <= drive_low_in;
         busy_res_ff     <= (phase_in != PH_IDLE);
         result_valid_ff <= result_valid_in;
         status_ff       <= status_in;
         temperature_ff  <= temperature_in;
         in_range_ff     <= in_range_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.drive_low    = drive_low_ff;
   assign rsp_ch.busy_res     = busy_res_ff;
   assign rsp_ch.result_valid = result_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.temperature  = temperature_ff;
   assign rsp_ch.in_range     = in_range_ff;

endmodule
`default_nettype wire
